### src/kcl_pkg.sv
// Shared types and constants of the keypad code lock.
// Holds the entry state struct, key codes, register indexes and the key digit table.
// No dependencies.
package kcl_pkg;

    localparam int NUM_KEYS    = 12;
    localparam int NIBBLES     = 16;
    localparam int STORE_W     = 4 * NIBBLES;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [3:0] KEY_CLEAR = 4'd0;
    localparam logic [3:0] KEY_ENTER = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_DIGITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_LENGTH = 2'd1;

    localparam logic [STORE_W-1:0] CODE_DIGITS_RESET = 64'h7331;
    localparam logic [COUNT_W-1:0] CODE_LENGTH_RESET = 5'd4;

    typedef struct packed {
        logic [STORE_W-1:0] store;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } entry_t;

    localparam entry_t ENTRY_CLEAR = '{store: '0, count: '0, ovf: 1'b0};

    function automatic logic [3:0] key_digit(input logic [3:0] key);
        logic [3:0] d;
        case (key)
            4'd1:    d = 4'd7;
            4'd2:    d = 4'd4;
            4'd3:    d = 4'd1;
            4'd4:    d = 4'd0;
            4'd5:    d = 4'd8;
            4'd6:    d = 4'd5;
            4'd7:    d = 4'd2;
            4'd9:    d = 4'd9;
            4'd10:   d = 4'd6;
            4'd11:   d = 4'd3;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

### src/kcl_append.sv
// Appends the digits of a group of freshly pressed keys to the entry, in key order.
// Depends on kcl_pkg for the entry state struct.
module kcl_append #(
    parameter int N          = 7,
    parameter int MAX_DIGITS = 16
) (
    input  kcl_pkg::entry_t  entry_in,
    input  logic [4*N-1:0]   digits,
    input  logic [N-1:0]     valid,
    output kcl_pkg::entry_t  entry_out
);

    logic [kcl_pkg::COUNT_W-1:0] pos;

    always_comb begin
        entry_out = entry_in;
        pos       = entry_in.count;
        for (int j = 0; j < N; j++) begin
            if (valid[j]) begin
                if (pos < kcl_pkg::COUNT_W'(MAX_DIGITS)) begin
                    entry_out.store[{pos[3:0], 2'b00} +: 4] = digits[4*j +: 4];
                    pos = pos + 1'b1;
                end else begin
                    entry_out.ovf = 1'b1;
                end
            end
        end
        entry_out.count = pos;
    end

endmodule

### src/kcl_match.sv
// Compares the held entry against the configured code.
// Depends on kcl_pkg for the entry state struct and widths.
module kcl_match (
    input  kcl_pkg::entry_t              entry,
    input  logic [kcl_pkg::STORE_W-1:0]  code_digits,
    input  logic [kcl_pkg::COUNT_W-1:0]  code_length,
    output logic                         match
);

    logic [kcl_pkg::NIBBLES-1:0] eq;

    always_comb begin
        for (int i = 0; i < kcl_pkg::NIBBLES; i++) begin
            eq[i] = (entry.store[4*i +: 4] == code_digits[4*i +: 4]) ||
                    (kcl_pkg::COUNT_W'(i) >= entry.count);
        end
        match = !entry.ovf && (entry.count == code_length) && (&eq);
    end

endmodule

### src/keypad_code_lock.sv
// Top level of the keypad code lock: state registers, key decode and output skid buffer.
// Depends on kcl_pkg, kcl_append and kcl_match.
//
//  channel  | direction | fields (lowest bit up)
//  s_       | in        | tdata: touch_bits[11:0], zero pad
//  m_       | out       | tdata: unlocked, accept_pulse, deny_pulse, entry_length[4:0],
//           |           |        entry_overflow, zero pad
//  cfg_     | in        | index: 0 code_digits, 1 code_length; data: value
//
// One sample per cycle while s_tready is high; each request is decoded in the cycle it
// is accepted and registered in the output register, or the skid register on a stall.
// A two-entry output buffer keeps s_tready high for one more request while m_tready is low.
// Synchronous active-low reset clears lock, entry and previous touch, and loads the
// default code into the code registers.
// cfg_ready is always high; writes to unused indexes are dropped.
module keypad_code_lock #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kcl_pkg::IN_TDATA_W-1:0]     s_tdata,  // touch_bits[11:0], pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kcl_pkg::OUT_TDATA_W-1:0]    m_tdata,  // unlocked, accept_pulse,
                                                         // deny_pulse, entry_length[4:0],
                                                         // entry_overflow, pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kcl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [kcl_pkg::STORE_W-1:0]     code_digits_reg;
    logic [kcl_pkg::COUNT_W-1:0]     code_length_reg;
    logic [kcl_pkg::NUM_KEYS-1:0]    prev_touch_reg;
    kcl_pkg::entry_t                 entry_reg;
    logic                            lock_reg;

    logic [kcl_pkg::NUM_KEYS-1:0]    touch;
    logic [kcl_pkg::NUM_KEYS-1:0]    fresh;
    kcl_pkg::entry_t                 entry_start;
    kcl_pkg::entry_t                 entry_low;
    kcl_pkg::entry_t                 entry_mid;
    kcl_pkg::entry_t                 entry_next;
    logic [27:0]                     digits_low;
    logic [11:0]                     digits_high;
    logic                            match;
    logic                            accept;
    logic                            deny;
    logic                            lock_next;
    logic                            acc;
    logic [kcl_pkg::OUT_TDATA_W-1:0] result;

    logic                            out_valid_reg;
    logic [kcl_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            skid_valid_reg;
    logic [kcl_pkg::OUT_TDATA_W-1:0] skid_data_reg;

    assign touch = s_tdata[kcl_pkg::NUM_KEYS-1:0];
    assign fresh = touch & ~prev_touch_reg;
    assign acc   = s_tvalid && s_tready;

    always_comb begin
        for (int j = 0; j < 7; j++) begin
            digits_low[4*j +: 4] = kcl_pkg::key_digit(kcl_pkg::KEY_CLEAR + 4'(j + 1));
        end
        for (int j = 0; j < 3; j++) begin
            digits_high[4*j +: 4] = kcl_pkg::key_digit(kcl_pkg::KEY_ENTER + 4'(j + 1));
        end
    end

    assign entry_start = fresh[kcl_pkg::KEY_CLEAR] ? kcl_pkg::ENTRY_CLEAR : entry_reg;

    kcl_append #(.N(7), .MAX_DIGITS(MAX_DIGITS)) u_append_low (
        .entry_in  (entry_start),
        .digits    (digits_low),
        .valid     (fresh[7:1]),
        .entry_out (entry_low)
    );

    kcl_match u_match (
        .entry       (entry_low),
        .code_digits (code_digits_reg),
        .code_length (code_length_reg),
        .match       (match)
    );

    assign accept    = fresh[kcl_pkg::KEY_ENTER] && match;
    assign deny      = fresh[kcl_pkg::KEY_ENTER] && !match;
    assign entry_mid = fresh[kcl_pkg::KEY_ENTER] ? kcl_pkg::ENTRY_CLEAR : entry_low;
    assign lock_next = lock_reg ^ accept;

    kcl_append #(.N(3), .MAX_DIGITS(MAX_DIGITS)) u_append_high (
        .entry_in  (entry_mid),
        .digits    (digits_high),
        .valid     (fresh[11:9]),
        .entry_out (entry_next)
    );

    assign result = {7'b0, entry_next.ovf, entry_next.count, deny, accept, lock_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_digits_reg <= kcl_pkg::CODE_DIGITS_RESET;
            code_length_reg <= kcl_pkg::CODE_LENGTH_RESET;
            prev_touch_reg  <= '0;
            entry_reg       <= kcl_pkg::ENTRY_CLEAR;
            lock_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    kcl_pkg::CFG_CODE_DIGITS: code_digits_reg <= cfg_data;
                    kcl_pkg::CFG_CODE_LENGTH: code_length_reg <= cfg_data[kcl_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                prev_touch_reg <= touch;
                entry_reg      <= entry_next;
                lock_reg       <= lock_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || acc;
            skid_valid_reg <= 1'b0;
        end else if (acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (acc) begin
            skid_data_reg <= result;
        end
    end

    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    a_pulse_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("accept and deny in one result");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_reg.count <= kcl_pkg::COUNT_W'(MAX_DIGITS))
        else $error("entry count beyond limit");

    a_skid_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_lock_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc |=> $stable(lock_reg))
        else $error("lock flag changed without a request");

    a_skid_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output");

endmodule

### tb/kcl_checker.sv
`timescale 1ns / 1ps
// Scoreboard for keypad_code_lock: snoops the touch, status and register channels,
// keeps its own copy of the lock state and compares each status word field by field.
// Depends on kcl_pkg.
module kcl_checker #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [kcl_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [kcl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [kcl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [31:0]                         errors,
    output logic [31:0]                         outstanding
);

    typedef struct packed {
        logic                        entry_overflow;
        logic [kcl_pkg::COUNT_W-1:0] entry_length;
        logic                        deny_pulse;
        logic                        accept_pulse;
        logic                        unlocked;
    } lock_status_t;

    // digit typed by each key, key 0 in the lowest nibble
    localparam logic [47:0] KEY_DIGITS = {4'd3, 4'd6, 4'd9, 4'd0, 4'd2, 4'd5,
                                          4'd8, 4'd0, 4'd1, 4'd4, 4'd7, 4'd0};

    logic [kcl_pkg::STORE_W-1:0]  code_q;
    logic [kcl_pkg::COUNT_W-1:0]  code_len_q;
    logic [11:0]                  prev_touch;
    kcl_pkg::entry_t              entry;
    logic                         lock_q;
    logic [8:0]                   status_q[$];
    lock_status_t                 want;
    lock_status_t                 got;

    function automatic logic entry_matches();
        logic [kcl_pkg::STORE_W-1:0] mask;
        if (entry.ovf || entry.count != code_len_q || entry.count > kcl_pkg::NIBBLES)
            return 1'b0;
        mask = (entry.count >= kcl_pkg::NIBBLES) ? '1
                                                 : (64'd1 << (entry.count * 4)) - 64'd1;
        return (entry.store & mask) == (code_q & mask);
    endfunction

    function automatic lock_status_t advance_lock(input logic [11:0] touch);
        lock_status_t res;
        logic [11:0]  fresh;
        fresh = touch & ~prev_touch;
        res = '0;
        for (int k = 0; k < kcl_pkg::NUM_KEYS; k++) begin
            if (!fresh[k])
                continue;
            if (k == kcl_pkg::KEY_CLEAR) begin
                entry = kcl_pkg::ENTRY_CLEAR;
            end else if (k == kcl_pkg::KEY_ENTER) begin
                if (entry_matches()) begin
                    lock_q = !lock_q;
                    res.accept_pulse = 1'b1;
                end else begin
                    res.deny_pulse = 1'b1;
                end
                entry = kcl_pkg::ENTRY_CLEAR;
            end else if (entry.count >= MAX_DIGITS || entry.count >= kcl_pkg::NIBBLES) begin
                entry.ovf = 1'b1;
            end else begin
                entry.store = entry.store
                            | ({60'd0, KEY_DIGITS[k*4 +: 4]} << (entry.count * 4));
                entry.count = entry.count + 1'b1;
            end
        end
        prev_touch = touch;
        res.unlocked       = lock_q;
        res.entry_length   = entry.count;
        res.entry_overflow = entry.ovf;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            code_q      = kcl_pkg::CODE_DIGITS_RESET;
            code_len_q  = kcl_pkg::CODE_LENGTH_RESET;
            prev_touch  = '0;
            entry       = kcl_pkg::ENTRY_CLEAR;
            lock_q      = 1'b0;
            status_q.delete();
            errors      = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    kcl_pkg::CFG_CODE_DIGITS: code_q = cfg_data;
                    kcl_pkg::CFG_CODE_LENGTH: code_len_q = cfg_data[kcl_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[8:0];
                if (status_q.size() == 0) begin
                    errors = errors + 1;
                    if (errors < 50)
                        $display("%0t: status %h with no request pending", $time, got);
                end else begin
                    want = status_q.pop_front();
                    if (got != want) begin
                        errors = errors + 1;
                        if (errors < 50) begin
                            if (got.unlocked != want.unlocked)
                                $display("%0t: unlocked expected %0d actual %0d",
                                         $time, want.unlocked, got.unlocked);
                            if (got.accept_pulse != want.accept_pulse)
                                $display("%0t: accept_pulse expected %0d actual %0d",
                                         $time, want.accept_pulse, got.accept_pulse);
                            if (got.deny_pulse != want.deny_pulse)
                                $display("%0t: deny_pulse expected %0d actual %0d",
                                         $time, want.deny_pulse, got.deny_pulse);
                            if (got.entry_length != want.entry_length)
                                $display("%0t: entry_length expected %0d actual %0d",
                                         $time, want.entry_length, got.entry_length);
                            if (got.entry_overflow != want.entry_overflow)
                                $display("%0t: entry_overflow expected %0d actual %0d",
                                         $time, want.entry_overflow, got.entry_overflow);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                status_q.push_back(advance_lock(s_tdata[11:0]));
            outstanding <= status_q.size();
        end
    end

endmodule

### tb/tb_keypad_code_lock.sv
`timescale 1ns / 1ps
// Testbench top for keypad_code_lock: drives touch samples and code register writes,
// stalls the status channel at random and reports the verdict of kcl_checker.
// Depends on kcl_pkg, kcl_checker and the keypad_code_lock RTL.
module tb_keypad_code_lock;

    localparam int STALL_LIMIT = 2000;
    localparam logic [kcl_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [kcl_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [kcl_pkg::IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b1;
    logic [kcl_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [kcl_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;
    logic [31:0]                      errors;
    logic [31:0]                      outstanding;

    bit                               idle_on   = 1'b1;
    int                               touches_sent = 0;
    int                               quiet_cycles = 0;
    logic [kcl_pkg::STORE_W-1:0]      code_val  = kcl_pkg::CODE_DIGITS_RESET;
    logic [kcl_pkg::COUNT_W-1:0]      code_len  = kcl_pkg::CODE_LENGTH_RESET;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    keypad_code_lock u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kcl_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always begin
        @(posedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("keypad_code_lock: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int key_of_digit(input logic [3:0] d);
        case (d)
            4'd7:    return 1;
            4'd4:    return 2;
            4'd1:    return 3;
            4'd0:    return 4;
            4'd8:    return 5;
            4'd5:    return 6;
            4'd2:    return 7;
            4'd9:    return 9;
            4'd6:    return 10;
            4'd3:    return 11;
            default: return -1;
        endcase
    endfunction

    function automatic int random_digit_key();
        int k;
        k = $urandom_range(1, 10);
        return (k >= kcl_pkg::KEY_ENTER) ? k + 1 : k;
    endfunction

    function automatic logic [kcl_pkg::STORE_W-1:0] rand_decimal_code();
        logic [kcl_pkg::STORE_W-1:0] c;
        c = '0;
        for (int i = 0; i < kcl_pkg::NIBBLES; i++)
            c[i*4 +: 4] = 4'($urandom_range(0, 9));
        return c;
    endfunction

    task automatic send_touch(input logic [11:0] touch);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, touch};
        do @(posedge aclk); while (!s_tready);
        touches_sent++;
    endtask

    task automatic press_key(input int k);
        send_touch(12'd1 << k);
        send_touch(12'd0);
    endtask

    task automatic enter_code(input bit corrupt);
        int slip;
        int k;
        slip = corrupt ? $urandom_range(0, kcl_pkg::NIBBLES - 1) : -1;
        for (int i = 0; i < code_len && i < kcl_pkg::NIBBLES; i++) begin
            k = key_of_digit(code_val[i*4 +: 4]);
            if (k < 0 || i == slip)
                k = random_digit_key();
            press_key(k);
        end
        press_key(int'(kcl_pkg::KEY_ENTER));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [kcl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [kcl_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_code(input logic [kcl_pkg::STORE_W-1:0] digits,
                            input logic [kcl_pkg::COUNT_W-1:0] len,
                            input bit stray);
        logic [kcl_pkg::CFG_DATA_W-1:0] noise;
        noise = {$urandom, $urandom};
        if (stray) begin
            write_reg(CFG_SPARE_A, noise);
            write_reg(CFG_SPARE_B, ~noise);
        end
        write_reg(kcl_pkg::CFG_CODE_DIGITS, digits);
        write_reg(kcl_pkg::CFG_CODE_LENGTH,
                  {noise[kcl_pkg::CFG_DATA_W-1:kcl_pkg::COUNT_W], len});
        cfg_valid <= 1'b0;
        code_val = digits;
        code_len = len;
    endtask

    initial begin
        int phase_end;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // default code: type it, enter, then try again on an empty entry
        send_touch(12'h000);
        send_touch(12'h008);
        send_touch(12'h800);
        send_touch(12'h000);
        send_touch(12'h800);
        send_touch(12'h002);
        send_touch(12'h100);
        send_touch(12'h000);
        send_touch(12'h100);
        // all keys at once, then ten more digits in one sample, enter and clear
        send_touch(12'hFFF);
        send_touch(12'h000);
        send_touch(12'hEFE);
        send_touch(12'h100);
        send_touch(12'h001);
        // digits, enter and more digits in one sample; clear plus enter together
        send_touch(12'hFFF);
        send_touch(12'h000);
        send_touch(12'h101);
        // relock with the same code
        send_touch(12'h000);
        send_touch(12'h008);
        send_touch(12'h800);
        send_touch(12'h000);
        send_touch(12'h800);
        send_touch(12'h002);
        send_touch(12'h100);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0:       set_code({$urandom, $urandom}, 5'd0, 1'b0);
                1:       set_code(rand_decimal_code(), 5'd16, 1'b0);
                2:       set_code('1, 5'd31, 1'b1);
                3:       set_code('0, 5'($urandom_range(1, 8)), 1'b0);
                default: set_code(rand_decimal_code(), 5'($urandom_range(1, 6)), 1'b0);
            endcase
            idle_on = (phase != 5);
            phase_end = touches_sent + 150;
            while (touches_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: enter_code($urandom_range(0, 3) == 0);
                    5, 6: begin
                        repeat ($urandom_range(0, 20)) press_key(random_digit_key());
                        press_key(int'(kcl_pkg::KEY_ENTER));
                    end
                    7: begin
                        repeat ($urandom_range(1, 5)) press_key(random_digit_key());
                        press_key(int'(kcl_pkg::KEY_CLEAR));
                    end
                    default: repeat ($urandom_range(1, 5))
                        send_touch(12'($urandom_range(0, 4095)));
                endcase
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("keypad_code_lock: match");
        else
            $display("keypad_code_lock: mismatch");
        $finish;
    end

endmodule
